// ----- hdl/dfrs_pkg.sv -----
// Shared types, command and result codes for the frame ring DMA sequencer.
package dfrs_pkg;

	// Ring geometry
	localparam int MAX_SLOTS = 256;
	localparam int SLOT_W    = 9;
	localparam int IDX_W     = 8;

	// Command kinds carried in the input tuser
	localparam logic [2:0] ACT_START     = 3'd0;
	localparam logic [2:0] ACT_STATUS    = 3'd1;
	localparam logic [2:0] ACT_TIMEOUT   = 3'd2;
	localparam logic [2:0] ACT_RESET_IDX = 3'd3;
	localparam logic [2:0] ACT_RESET_DMA = 3'd4;

	// Result codes
	localparam logic [2:0] RC_OK      = 3'd0;
	localparam logic [2:0] RC_INVALID = 3'd1;
	localparam logic [2:0] RC_BUSY    = 3'd2;
	localparam logic [2:0] RC_IO      = 3'd3;
	localparam logic [2:0] RC_TIMEOUT = 3'd4;
	localparam logic [2:0] RC_WAIT    = 3'd5;

	// DMA status bits
	localparam logic [31:0] ST_IDLE     = 32'h0000_0002;
	localparam logic [31:0] ST_ERR_BITS = 32'h0000_0070;
	localparam logic [31:0] ST_IOC      = 32'h0000_1000;

	// Status clear patterns
	localparam logic [14:0] CLR_NONE = 15'h0000;
	localparam logic [14:0] CLR_KICK = 15'h7000;
	localparam logic [14:0] CLR_ACK  = 15'h1000;
	localparam logic [14:0] CLR_ERR  = 15'h4000;

	// Configuration register indexes
	localparam logic [1:0] REG_BASE   = 2'd0;
	localparam logic [1:0] REG_LENGTH = 2'd1;
	localparam logic [1:0] REG_SLOTS  = 2'd2;

	// Configuration reset values
	localparam logic [31:0]       BASE_RST   = 32'h0000_0000;
	localparam logic [31:0]       LENGTH_RST = 32'h0200_0000;
	localparam logic [SLOT_W-1:0] SLOTS_RST  = 9'd2;

	typedef struct packed {
		logic [31:0]       base;
		logic [31:0]       length;
		logic [SLOT_W-1:0] slots;
	} cfg_t;

	// Input word: frame_count in the low bits, padded to 48 bits
	typedef struct packed {
		logic [6:0]        pad;
		logic [31:0]       status_word;
		logic [SLOT_W-1:0] frame_count;
	} in_word_t;

	typedef struct packed {
		logic [2:0] action;
		in_word_t   data;
	} cmd_t;

	// Result word: result_code in the low bits, padded to 168 bits
	typedef struct packed {
		logic [2:0]        pad;
		logic [31:0]       last_kick_address;
		logic [31:0]       last_status;
		logic [SLOT_W-1:0] frames_pending;
		logic [IDX_W-1:0]  producer_index;
		logic              reset_request;
		logic [14:0]       status_clear_bits;
		logic [31:0]       kick_length;
		logic [31:0]       kick_address;
		logic              kick_valid;
		logic [2:0]        result_code;
	} res_t;

endpackage

// ----- hdl/dfrs_core.sv -----
// Sequencer state and the per-command step logic.
module dfrs_core
	import dfrs_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic step_en,
	input  logic wrap_load,
	output logic wrap_busy,
	input  cmd_t cmd,
	input  cfg_t cfg,
	output res_t res
);

	logic [IDX_W-1:0]  slot_index_q;
	logic [SLOT_W-1:0] pending_q;
	logic [31:0]       seen_status_q;
	logic [31:0]       kicked_q;

	logic [IDX_W-1:0]  slot_index_n;
	logic [SLOT_W-1:0] pending_n;
	logic [31:0]       seen_status_n;
	logic [31:0]       kicked_n;

	logic [SLOT_W-1:0] eff_slots;
	logic [SLOT_W-1:0] pending_dec;
	logic [IDX_W-1:0]  launch_index;
	logic [39:0]       product;
	logic [31:0]       launch_addr;
	logic              kick;
	logic [2:0]        rc;
	logic [14:0]       clr;
	logic              reset_req;
	logic              idx_moved;

	// Wrapped successor of the slot index, kept ready for the next completion
	logic [IDX_W-1:0]  next_idx_q;
	logic [IDX_W-1:0]  next_idx_n;
	logic [SLOT_W-1:0] moved_inc;
	logic              wrap_busy_q;
	logic [3:0]        wrap_bit_q;
	logic [SLOT_W:0]   wrap_rem_q;
	logic [SLOT_W-1:0] wrap_num;
	logic [SLOT_W:0]   wrap_shift;
	logic [SLOT_W:0]   wrap_rem_n;

	// Slot count of zero acts as one, above the ring maximum it saturates
	always_comb begin
		if (cfg.slots == '0) begin
			eff_slots = SLOT_W'(1);
		end else if (cfg.slots > SLOT_W'(MAX_SLOTS)) begin
			eff_slots = SLOT_W'(MAX_SLOTS);
		end else begin
			eff_slots = cfg.slots;
		end
	end

	assign pending_dec = pending_q - SLOT_W'(1);

	// Destination address of a kick
	assign product     = {8'b0, cfg.length} * {32'b0, launch_index};
	assign launch_addr = cfg.base + product[31:0];

	// Command decode and next state
	always_comb begin
		rc            = RC_OK;
		kick          = 1'b0;
		clr           = CLR_NONE;
		reset_req     = 1'b0;
		idx_moved     = 1'b0;
		launch_index  = slot_index_q;
		slot_index_n  = slot_index_q;
		pending_n     = pending_q;
		seen_status_n = seen_status_q;
		unique case (cmd.action)
			ACT_START: begin
				if (cmd.data.frame_count == '0 || cmd.data.frame_count > eff_slots) begin
					rc = RC_INVALID;
				end else if (pending_q != '0) begin
					rc = RC_BUSY;
				end else if (cfg.length[1:0] != 2'b00) begin
					rc = RC_INVALID;
				end else begin
					pending_n = cmd.data.frame_count;
					kick      = 1'b1;
				end
			end
			ACT_STATUS: begin
				if (pending_q != '0) begin
					seen_status_n = cmd.data.status_word;
					if ((cmd.data.status_word & ST_ERR_BITS) != '0) begin
						clr       = CLR_ERR;
						reset_req = 1'b1;
						pending_n = '0;
						rc        = RC_IO;
					end else if ((cmd.data.status_word & ST_IDLE) != '0 &&
						(cmd.data.status_word & ST_IOC) != '0) begin
						// frame done: advance ring, kick next if any remain
						slot_index_n = next_idx_q;
						idx_moved    = 1'b1;
						pending_n    = pending_dec;
						if (pending_dec != '0) begin
							launch_index = next_idx_q;
							kick         = 1'b1;
							rc           = RC_WAIT;
						end else begin
							clr = CLR_ACK;
						end
					end else begin
						rc = RC_WAIT;
					end
				end
			end
			ACT_TIMEOUT: begin
				if (pending_q != '0) begin
					reset_req = 1'b1;
					pending_n = '0;
					rc        = RC_TIMEOUT;
				end
			end
			ACT_RESET_IDX: begin
				slot_index_n = '0;
				idx_moved    = 1'b1;
			end
			ACT_RESET_DMA: begin
				reset_req = 1'b1;
			end
			default: begin
				rc = RC_INVALID;
			end
		endcase
		if (kick) begin
			clr = CLR_KICK;
		end
	end

	assign kicked_n = kick ? launch_addr : kicked_q;

	// A freshly moved index is always below the slot count: wrap is one compare
	assign moved_inc  = {1'b0, slot_index_n} + SLOT_W'(1);
	assign next_idx_n = (moved_inc == eff_slots) ? '0 : moved_inc[IDX_W-1:0];

	// Restoring remainder, one dividend bit per cycle, for a possibly stale index
	assign wrap_num   = {1'b0, slot_index_q} + SLOT_W'(1);
	assign wrap_shift = {wrap_rem_q[SLOT_W-1:0], wrap_num[wrap_bit_q]};
	assign wrap_rem_n = (wrap_shift >= {1'b0, eff_slots}) ?
		wrap_shift - {1'b0, eff_slots} : wrap_shift;

	// Successor index: rebuilt after reset and slot count writes, else kept current
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_idx_q  <= '0;
			wrap_busy_q <= 1'b1;
			wrap_bit_q  <= 4'(SLOT_W - 1);
			wrap_rem_q  <= '0;
		end else if (wrap_load) begin
			wrap_busy_q <= 1'b1;
			wrap_bit_q  <= 4'(SLOT_W - 1);
			wrap_rem_q  <= '0;
		end else if (wrap_busy_q) begin
			wrap_rem_q <= wrap_rem_n;
			wrap_bit_q <= wrap_bit_q - 4'd1;
			if (wrap_bit_q == '0) begin
				wrap_busy_q <= 1'b0;
				next_idx_q  <= wrap_rem_n[IDX_W-1:0];
			end
		end else if (step_en && idx_moved) begin
			next_idx_q <= next_idx_n;
		end
	end

	assign wrap_busy = wrap_busy_q;

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_index_q  <= '0;
			pending_q     <= '0;
			seen_status_q <= '0;
			kicked_q      <= '0;
		end else if (step_en) begin
			slot_index_q  <= slot_index_n;
			pending_q     <= pending_n;
			seen_status_q <= seen_status_n;
			kicked_q      <= kicked_n;
		end
	end

	// Result word
	always_comb begin
		res                   = '0;
		res.result_code       = rc;
		res.kick_valid        = kick;
		res.kick_address      = kick ? launch_addr : 32'h0;
		res.kick_length       = kick ? cfg.length : 32'h0;
		res.status_clear_bits = clr;
		res.reset_request     = reset_req;
		res.producer_index    = slot_index_n;
		res.frames_pending    = pending_n;
		res.last_status       = seen_status_n;
		res.last_kick_address = kicked_n;
	end

endmodule

// ----- hdl/dma_frame_ring_sequencer_top.sv -----
// Top level: config registers, input stage, sequencer core and result register.
// Each input word is taken into the input register, stepped, and presented from the result register.
// Throughput: one word per cycle while no index rebuild stalls the step; input register,
// combinational step logic (8x32 address multiply, add) and result register flow under
// backpressure. Stalls: after reset and after each slot count write the step waits
// while the wrapped next index is rebuilt one bit per cycle.
// Reset: config registers to defaults, ring state to zero, both stages empty.
module dma_frame_ring_sequencer_top
	import dfrs_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	// config write port
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [31:0]  cfg_wdata,
	// command stream
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [47:0]  s_axis_tdata,  // frame_count[8:0], status_word[40:9]
	input  logic [2:0]   s_axis_tuser,  // action[2:0]
	// result stream
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// result_code[2:0], kick_valid[3], kick_address[35:4], kick_length[67:36],
	// status_clear_bits[82:68], reset_request[83], producer_index[91:84],
	// frames_pending[100:92], last_status[132:101], last_kick_address[164:133]
	output logic [167:0] m_axis_tdata
);

	cfg_t cfg_q;
	logic valid_s1;
	cmd_t cmd_s1;
	logic out_valid_q;
	res_t out_q;
	res_t step_res;
	logic advance;
	logic wrap_load;
	logic wrap_busy;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base   <= BASE_RST;
			cfg_q.length <= LENGTH_RST;
			cfg_q.slots  <= SLOTS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BASE:   cfg_q.base   <= cfg_wdata;
				REG_LENGTH: cfg_q.length <= cfg_wdata;
				REG_SLOTS:  cfg_q.slots  <= cfg_wdata[SLOT_W-1:0];
				default: ;
			endcase
		end
	end

	assign wrap_load = cfg_we && (cfg_index == REG_SLOTS);

	// Stage 1 moves on when no index rebuild is running and the result register is free or being drained
	assign advance       = valid_s1 && !wrap_busy && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			cmd_s1 <= {s_axis_tuser, s_axis_tdata};
		end
	end

	dfrs_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_en   (advance),
		.wrap_load (wrap_load),
		.wrap_busy (wrap_busy),
		.cmd       (cmd_s1),
		.cfg       (cfg_q),
		.res       (step_res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= step_res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;

endmodule

// ----- hdl/dfrs_checker.sv -----
// Port-level checks on the sequencer result stream, bound to the top level.
module dfrs_checker
	import dfrs_pkg::*;
(
	input logic         clk,
	input logic         arst_n,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [167:0] m_axis_tdata
);

	res_t r;

	assign r = res_t'(m_axis_tdata);

	// A stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result word changed while stalled");

	// A kick clears the CLR_KICK status bits, records its address and leaves frames pending
	a_kick: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && r.kick_valid |->
		r.status_clear_bits == CLR_KICK && r.kick_address == r.last_kick_address &&
		r.frames_pending != '0 && (r.result_code == RC_OK || r.result_code == RC_WAIT))
		else $error("inconsistent kick word");

	// Without a kick the transfer fields are zero
	a_nokick: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !r.kick_valid |-> r.kick_address == '0 && r.kick_length == '0)
		else $error("transfer fields set without kick");

	// Error and timeout abort everything and request a soft reset
	a_abort: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (r.result_code == RC_IO || r.result_code == RC_TIMEOUT) |->
		r.reset_request && r.frames_pending == '0 && !r.kick_valid)
		else $error("abort did not clear pending frames");

endmodule

bind dma_frame_ring_sequencer_top dfrs_checker u_dfrs_checker (.*);
